// File: rtl/sme_pkg.sv
// Shared types and constants for the sparse matrix entry store.
// Holds field widths, operation and status codes, register indexes and the config struct.
// No dependencies.
package sme_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int CAPACITY_DEF   = 64;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths of the command and result ports
  localparam int FUNC_W   = 1;
  localparam int COORD_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Configuration register file
  localparam int CFG_W     = 17;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

  // Register indexes (paddr bit 2)
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Matrix size seen by the controller
  typedef struct packed {
    logic [CFG_W-1:0] row_count;
    logic [CFG_W-1:0] column_count;
  } cfg_t;

endpackage

// File: rtl/sme_mem.sv
// Entry memory of the sparse matrix entry store: one write port, one registered read port.
// Each word holds {row, column, value} of one slot. No package dependencies.
module sme_mem #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/sme_ctrl.sv
// Scan controller of the sparse matrix entry store: walks the entry memory, finds the
// matching and first free slot, then applies the operation. Uses sme_pkg; drives sme_mem.
module sme_ctrl
  import sme_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ADDR_W     = $clog2(CAPACITY),
  parameter int WORD_W     = 2 * COORD_BITS + VALUE_W
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                start,
  input  logic [FUNC_W-1:0]   func,
  input  logic [COORD_W-1:0]  row,
  input  logic [COORD_W-1:0]  column,
  input  logic [VALUE_W-1:0]  value,
  output logic                busy,
  output logic                done,
  output logic [VALUE_W-1:0]  read_value,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  entry_count,
  output logic                mem_rd_en,
  output logic [ADDR_W-1:0]   mem_rd_addr,
  input  logic [WORD_W-1:0]   mem_rd_data,
  output logic                mem_wr_en,
  output logic [ADDR_W-1:0]   mem_wr_addr,
  output logic [WORD_W-1:0]   mem_wr_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_ACT
  } state_t;

  state_t state;

  // Latched command
  logic [FUNC_W-1:0]     func_q;
  logic [COORD_BITS-1:0] row_q;
  logic [COORD_BITS-1:0] col_q;
  logic [VALUE_W-1:0]    value_q;
  logic                  oor_q;

  // Scan pointer and compare pipeline
  logic [ADDR_W-1:0] idx;
  logic              cmp_vld;
  logic [ADDR_W-1:0] cmp_idx;

  // Scan results
  logic              hit;
  logic [ADDR_W-1:0] hit_idx;
  logic [VALUE_W-1:0] hit_value;
  logic              free_found;
  logic [ADDR_W-1:0] free_idx;

  // Slot occupancy
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    cnt;

  // Incoming coordinates at the stored width
  logic [COORD_BITS-1:0] row_in;
  logic [COORD_BITS-1:0] col_in;
  logic                  oor_in;

  // Memory word fields
  logic [COORD_BITS-1:0] rd_row;
  logic [COORD_BITS-1:0] rd_col;
  logic [VALUE_W-1:0]    rd_val;

  // Operation decision
  logic                act_wr;
  logic [ADDR_W-1:0]   act_idx;
  logic                set_v;
  logic                clr_v;
  logic [STATUS_W-1:0] act_status;
  logic [VALUE_W-1:0]  act_rd;
  logic [CNT_W-1:0]    cnt_next;

  assign row_in = COORD_BITS'(row);
  assign col_in = COORD_BITS'(column);
  assign oor_in = (CMP_W'(row_in) >= CMP_W'(cfg.row_count)) ||
                  (CMP_W'(col_in) >= CMP_W'(cfg.column_count));

  assign rd_row = mem_rd_data[WORD_W-1 -: COORD_BITS];
  assign rd_col = mem_rd_data[VALUE_W +: COORD_BITS];
  assign rd_val = mem_rd_data[VALUE_W-1:0];

  assign busy = (state != ST_IDLE);

  // Issue one memory read per scan cycle
  assign mem_rd_en   = (state == ST_SCAN);
  assign mem_rd_addr = idx;

  // Decide the effect of the operation once the scan is complete
  always_comb begin
    act_wr     = 1'b0;
    act_idx    = hit_idx;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    act_status = STATUS_DONE;
    act_rd     = '0;
    if (oor_q) begin
      act_status = STATUS_RANGE;
    end else if (func_q == FUNC_READ) begin
      if (hit) begin
        act_rd = hit_value;
      end
    end else if (value_q != '0) begin
      if (hit) begin
        act_wr = 1'b1;
      end else if (free_found) begin
        act_wr  = 1'b1;
        act_idx = free_idx;
        set_v   = 1'b1;
      end else begin
        act_status = STATUS_FULL;
      end
    end else if (hit) begin
      clr_v = 1'b1;
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (set_v) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (clr_v) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  // Write back the entry on an update or insert
  assign mem_wr_en   = (state == ST_ACT) && act_wr;
  assign mem_wr_addr = act_idx;
  assign mem_wr_data = {row_q, col_q, value_q};

  // Sequencer, scan bookkeeping and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      cnt     <= '0;
      done    <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      done <= 1'b0;

      // Compare the word read in the previous cycle
      if (cmp_vld) begin
        if (valid[cmp_idx]) begin
          if (rd_row == row_q && rd_col == col_q) begin
            hit       <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_value <= rd_val;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            func_q     <= func;
            row_q      <= row_in;
            col_q      <= col_in;
            value_q    <= value;
            oor_q      <= oor_in;
            hit        <= 1'b0;
            free_found <= 1'b0;
            idx        <= '0;
            state      <= oor_in ? ST_ACT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld <= 1'b1;
          cmp_idx <= idx;
          idx     <= idx + ADDR_W'(1);
          if (idx == LAST_IDX) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // last compare happens in this cycle
          cmp_vld <= 1'b0;
          state   <= ST_ACT;
        end
        ST_ACT: begin
          if (set_v) begin
            valid[act_idx] <= 1'b1;
          end
          if (clr_v) begin
            valid[hit_idx] <= 1'b0;
          end
          cnt         <= cnt_next;
          done        <= 1'b1;
          read_value  <= act_rd;
          status      <= act_status;
          entry_count <= COUNT_W'(cnt_next);
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/sparse_matrix_entry_store.sv
// Sparse matrix entry store: a bounded coordinate list of nonzero (row, column, value) entries.
// Each command runs a full scan of the CAPACITY entry memory (one slot per cycle through
// its single read port) in ST_SCAN, then ST_WAIT for the last compare, then ST_ACT for the
// write-back; a coordinate outside the configured size skips the scan and goes straight to
// ST_ACT. busy is high while a command is in progress, and the next command may start in the
// cycle that done is shown. Results are registered with the one-cycle done strobe and cannot
// be held off. The entry memory needs no clearing pass after reset; slot occupancy lives in
// flip-flops cleared by rst.
// Uses sme_pkg, sme_ctrl and sme_mem.
module sparse_matrix_entry_store
  import sme_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // command
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func,
  input  logic [COORD_W-1:0]  row,
  input  logic [COORD_W-1:0]  column,
  input  logic [VALUE_W-1:0]  value,
  // result
  output logic                done,
  output logic [VALUE_W-1:0]  read_value,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  entry_count
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int WORD_W = 2 * COORD_BITS + VALUE_W;

  cfg_t cfg;

  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;

  assign pready = 1'b1;

  // Take a register write at the access phase of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count    <= CFG_RESET;
      cfg.column_count <= CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ROW_COUNT:    cfg.row_count    <= pwdata[CFG_W-1:0];
        REG_COLUMN_COUNT: cfg.column_count <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[2])
      REG_ROW_COUNT:    prdata = PDATA_W'(cfg.row_count);
      REG_COLUMN_COUNT: prdata = PDATA_W'(cfg.column_count);
      default:          prdata = '0;
    endcase
  end

  sme_ctrl #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .ADDR_W     (ADDR_W),
    .WORD_W     (WORD_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (start),
    .func        (func),
    .row         (row),
    .column      (column),
    .value       (value),
    .busy        (busy),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  sme_mem #(
    .DEPTH  (CAPACITY),
    .WIDTH  (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

`ifndef ASSERT_OFF
  // Every accepted command makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // A result is only shown once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done strobe while busy");

  // Leaving busy always delivers a result
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("command finished without a result");

  // Full is only reported when every slot is taken
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_FULL |-> entry_count == COUNT_W'(CAPACITY))
    else $error("store full reported with free slots");
`endif

endmodule
